// ----- src/tlr_pkg.sv -----
// tlr_pkg: types, codes and widths for the linear trend forecaster.
// Used by tlr_mul, tlr_div and time_index_linear_regression_top.
package tlr_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SY_W   = 32;
  localparam int SXY_W  = 48;
  localparam int Q_W    = 32;
  localparam int MC_W   = 34;
  localparam int MP_W   = 20;
  localparam int PR_W   = MC_W + MP_W;
  localparam int NUM_W  = 56;
  localparam int DEN_W  = 50;
  localparam int FRAC_W = 16;
  localparam int DVD_W  = NUM_W + FRAC_W;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_FORECAST = 2'd2,
    OP_NONE     = 2'd3
  } tlr_op_t;

  typedef enum logic [1:0] {
    ST_FIT_VALID = 2'd0,
    ST_FEW       = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNUSED    = 2'd3
  } tlr_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MXY, S_MT1, S_MT2, S_MBD, S_MT3, S_DB, S_DA, S_MFC, S_FIN
  } tlr_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] sample;
    logic signed [15:0] horizon;
  } tlr_in_t;

  typedef struct packed {
    logic signed [31:0] forecast;
    logic signed [31:0] slope_out;
    logic signed [31:0] intercept_out;
    logic [1:0]         status;
  } tlr_out_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > NUM_W'(64'sd2147483647))        r = 32'sh7FFF_FFFF;
    else if (v < -NUM_W'(64'sd2147483648))  r = 32'sh8000_0000;
    else                                     r = v[Q_W-1:0];
    return r;
  endfunction

endpackage

// ----- src/time_index_linear_regression_top.sv -----
// time_index_linear_regression_top: least-squares line fit over sample index with forecast.
// Depends on tlr_pkg, tlr_mul and tlr_div.
//
// Each item is a clear, add, forecast or the unused opcode and yields exactly
// one result item carrying the forecast (zero unless a forecast was asked), the
// current Q16.16 slope and intercept, and a status. Items are handled one at a
// time. Clear, a rejected add and the unused opcode go straight to the finish
// state. A forecast, or an add that brings the count to one, runs one serial
// multiply. An add that refits runs five serial multiplies and two serial
// divides in series. A finished result is held in an output register, so the
// next item can be taken while it waits; a result that is still unread when the
// next one is finished stalls the block until it is taken.
module time_index_linear_regression_top import tlr_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tlr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tlr_out_t out_data
);

  tlr_state_t state_r, state_nxt;
  logic       go_r;

  logic [COUNT_BITS-1:0]   cnt_r;
  logic signed [SY_W-1:0]  sy_r;
  logic signed [SXY_W-1:0] sxy_r;
  logic signed [Q_W-1:0]   slope_r;
  logic signed [Q_W-1:0]   icpt_r;
  logic signed [Q_W-1:0]   fc_r;
  logic signed [SY_W-1:0]  y_r;
  logic signed [15:0]      h_r;
  logic                    rej_r;
  logic signed [NUM_W-1:0] bnum_r;
  logic signed [NUM_W-1:0] anum_r;
  logic [Q_W-1:0]          aden_r;
  logic [DEN_W-1:0]        bden_r;
  tlr_out_t                out_r;
  logic                    out_valid_r;

  logic                    mul_start, mul_done;
  logic signed [MC_W-1:0]  mul_a;
  logic signed [MP_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  mul_prod;
  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic signed [Q_W-1:0]   div_quo;

  logic                    accept;
  logic                    full;
  logic                    fin_ok;
  logic signed [NUM_W-1:0] sxy_x;
  logic signed [NUM_W-1:0] prod_x;
  logic signed [NUM_W-1:0] d1;
  logic signed [NUM_W-1:0] fc_sum;
  logic [MP_W-1:0]         cnt_p1;
  logic [MP_W-1:0]         cnt_m1;
  logic [MP_W-1:0]         cnt_4p2;
  logic signed [MP_W-1:0]  xpos;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign full    = (cnt_r == {COUNT_BITS{1'b1}});
  assign fin_ok  = !out_valid_r || out_ready;

  assign sxy_x   = NUM_W'(sxy_r);
  assign prod_x  = NUM_W'(mul_prod);
  assign d1      = (sxy_x <<< 1) - prod_x;
  assign fc_sum  = prod_x + NUM_W'(icpt_r);
  assign cnt_p1  = MP_W'(cnt_r) + MP_W'(1);
  assign cnt_m1  = MP_W'(cnt_r) - MP_W'(1);
  assign cnt_4p2 = (MP_W'(cnt_r) << 2) + MP_W'(2);
  assign xpos    = $signed(MP_W'(cnt_r)) + MP_W'(h_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (tlr_op_t'(in_data.opcode))
            OP_ADD:      state_nxt = full ? S_FIN : S_MXY;
            OP_FORECAST: state_nxt = S_MFC;
            OP_CLEAR:    state_nxt = S_FIN;
            OP_NONE:     state_nxt = S_FIN;
          endcase
        end
      end
      S_MXY: if (mul_done) state_nxt = (cnt_r == COUNT_BITS'(1)) ? S_FIN : S_MT1;
      S_MT1: if (mul_done) state_nxt = S_MT2;
      S_MT2: if (mul_done) state_nxt = S_MBD;
      S_MBD: if (mul_done) state_nxt = S_MT3;
      S_MT3: if (mul_done) state_nxt = S_DB;
      S_DB:  if (div_done) state_nxt = S_DA;
      S_DA:  if (div_done) state_nxt = S_FIN;
      S_MFC: if (mul_done) state_nxt = S_FIN;
      S_FIN: if (fin_ok)   state_nxt = S_IDLE;
      default:             state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = MC_W'(sy_r);
    mul_b     = cnt_p1;
    div_num   = bnum_r;
    div_den   = bden_r;
    unique case (state_r)
      S_MXY: begin
        mul_start = go_r;
        mul_a     = MC_W'(y_r);
        mul_b     = MP_W'(cnt_r);
      end
      S_MT1: begin
        mul_start = go_r;
        mul_a     = MC_W'(sy_r);
        mul_b     = cnt_p1;
      end
      S_MT2: begin
        mul_start = go_r;
        mul_a     = $signed(MC_W'(cnt_r));
        mul_b     = cnt_m1;
      end
      S_MBD: begin
        mul_start = go_r;
        mul_a     = $signed(MC_W'(aden_r));
        mul_b     = cnt_p1;
      end
      S_MT3: begin
        mul_start = go_r;
        mul_a     = MC_W'(sy_r);
        mul_b     = cnt_4p2;
      end
      S_DB: begin
        div_start = go_r;
        div_num   = bnum_r;
        div_den   = bden_r;
      end
      S_DA: begin
        div_start = go_r;
        div_num   = anum_r;
        div_den   = DEN_W'(aden_r);
      end
      S_MFC: begin
        mul_start = go_r;
        mul_a     = MC_W'(slope_r);
        mul_b     = xpos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      slope_r     <= '0;
      icpt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
      if (state_r == S_FIN && fin_ok) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            y_r   <= SY_W'(signed'(in_data.sample[SAMPLE_BITS-1:0]));
            h_r   <= in_data.horizon;
            fc_r  <= '0;
            rej_r <= 1'b0;
            priority case (tlr_op_t'(in_data.opcode))
              OP_CLEAR: begin
                cnt_r   <= '0;
                sy_r    <= '0;
                sxy_r   <= '0;
                slope_r <= '0;
                icpt_r  <= '0;
              end
              OP_ADD: begin
                if (full) begin
                  rej_r <= 1'b1;
                end else begin
                  cnt_r <= cnt_r + 1'b1;
                  sy_r  <= sy_r + SY_W'(signed'(in_data.sample[SAMPLE_BITS-1:0]));
                end
              end
              default: ;
            endcase
          end
        end
        S_MXY: begin
          if (mul_done) begin
            sxy_r <= sxy_r + mul_prod[SXY_W-1:0];
            if (cnt_r == COUNT_BITS'(1)) begin
              slope_r <= '0;
              icpt_r  <= {sy_r[15:0], {FRAC_W{1'b0}}};
            end
          end
        end
        S_MT1: if (mul_done) bnum_r <= (d1 <<< 2) + (d1 <<< 1);
        S_MT2: if (mul_done) aden_r <= mul_prod[Q_W-1:0];
        S_MBD: if (mul_done) bden_r <= mul_prod[DEN_W-1:0];
        S_MT3: if (mul_done) anum_r <= prod_x - ((sxy_x <<< 2) + (sxy_x <<< 1));
        S_DB:  if (div_done) slope_r <= div_quo;
        S_DA:  if (div_done) icpt_r <= div_quo;
        S_MFC: if (mul_done) fc_r <= sat32(fc_sum);
        S_FIN: begin
          if (fin_ok) begin
            out_r.forecast      <= fc_r;
            out_r.slope_out     <= slope_r;
            out_r.intercept_out <= icpt_r;
            if (rej_r)
              out_r.status <= ST_FULL;
            else if (cnt_r >= COUNT_BITS'(2))
              out_r.status <= ST_FIT_VALID;
            else
              out_r.status <= ST_FEW;
          end
        end
        default: ;
      endcase
    end
  end

  tlr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tlr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/tlr_mul.sv -----
// tlr_mul: bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on tlr_pkg.
module tlr_mul import tlr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MC_W-1:0]  a,
  input  logic signed [MP_W-1:0]  b,
  output logic                    done,
  output logic signed [PR_W-1:0]  prod
);

  localparam int CNT_W = $clog2(MP_W);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [PR_W-1:0] mc_r;
  logic [MP_W-1:0]        mp_r;
  logic signed [PR_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(MP_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= PR_W'(a);
      mp_r  <= b;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        if (cnt_r == CNT_W'(MP_W - 1)) acc_r <= acc_r - mc_r;
        else                           acc_r <= acc_r + mc_r;
      end
      mc_r  <= mc_r <<< 1;
      mp_r  <= mp_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- src/tlr_div.sv -----
// tlr_div: bit-serial restoring divider giving trunc(num * 2^16 / den),
// saturated to signed Q16.16. Depends on tlr_pkg.
module tlr_div import tlr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [Q_W:0]       q_r;
  logic               big_r;
  logic               neg_r;
  logic [NUM_W-1:0]   mag;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [Q_W+1:0]     q_sh;

  assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign q_sh   = {q_r, ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {mag, {FRAC_W{1'b0}}};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
      neg_r <= num[NUM_W-1];
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      dvd_r <= dvd_r << 1;
      if (q_sh[Q_W+1:Q_W] != 2'b00) begin
        big_r <= 1'b1;
        q_r   <= {1'b1, {Q_W{1'b0}}};
      end else begin
        q_r   <= q_sh[Q_W:0];
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    if (neg_r) begin
      if (big_r || q_r > 33'h0_8000_0000) quo = 32'sh8000_0000;
      else                                quo = -$signed(q_r[Q_W-1:0]);
    end else begin
      if (big_r || q_r > 33'h0_7FFF_FFFF) quo = 32'sh7FFF_FFFF;
      else                                quo = $signed(q_r[Q_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ----- dv/tb_time_index_linear_regression_top.sv -----
// Testbench for time_index_linear_regression_top: drives clear, add, forecast and
// unused-opcode items, predicts the Q16.16 fit and status, and checks every result item.
// Depends on tlr_pkg and the RTL of time_index_linear_regression_top.
module tb_time_index_linear_regression_top;
  import tlr_pkg::*;

  localparam int    WATCHDOG_LIMIT = 20000;
  localparam int    DRAIN_CYCLES   = 400;
  localparam int    COUNT_FULL     = 65535;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tlr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tlr_out_t out_data;

  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       error_count = 0;
  int       quiet_cycles = 0;
  tlr_out_t expected_results[$];

  longint   fit_count;
  longint   fit_sum_y;
  longint   fit_sum_xy;
  longint   fit_slope;
  longint   fit_intercept;

  time_index_linear_regression_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(input longint v);
    longint r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r;
  endfunction

  // trunc(num * 2^16 / den) saturated; num * 2^16 can exceed 64 bits
  function automatic longint q16_quotient(input longint num, input longint den);
    logic [127:0] mag;
    logic [127:0] q;
    logic         neg;
    longint       r;
    neg = num < 0;
    mag = neg ? 128'(-num) : 128'(num);
    q = (mag << 16) / 128'(den);
    if (neg) begin
      if (q > 128'h8000_0000) r = SAT_LO;
      else r = -longint'(q);
    end else begin
      if (q > 128'h7FFF_FFFF) r = SAT_HI;
      else r = longint'(q);
    end
    return r;
  endfunction

  function automatic void clear_fit();
    fit_count = 0;
    fit_sum_y = 0;
    fit_sum_xy = 0;
    fit_slope = 0;
    fit_intercept = 0;
  endfunction

  function automatic tlr_out_t predict_trend(input tlr_in_t item);
    tlr_out_t res;
    longint   n;
    longint   y;
    logic     rejected;
    res = '0;
    rejected = 1'b0;
    case (tlr_op_t'(item.opcode))
      OP_CLEAR: clear_fit();
      OP_ADD: begin
        if (fit_count >= COUNT_FULL) begin
          rejected = 1'b1;
        end else begin
          y = longint'(item.sample);
          fit_count++;
          fit_sum_y += y;
          fit_sum_xy += fit_count * y;
          n = fit_count;
          if (n == 1) begin
            fit_slope = 0;
            fit_intercept = clamp32(fit_sum_y * 65536);
          end else begin
            fit_slope = q16_quotient(6 * (2 * fit_sum_xy - (n + 1) * fit_sum_y),
                                     n * (n - 1) * (n + 1));
            fit_intercept = q16_quotient((4 * n + 2) * fit_sum_y - 6 * fit_sum_xy,
                                         n * (n - 1));
          end
        end
      end
      OP_FORECAST:
        res.forecast = 32'(clamp32(fit_slope * (fit_count + longint'(item.horizon))
                                   + fit_intercept));
      default: ;
    endcase
    res.slope_out = 32'(fit_slope);
    res.intercept_out = 32'(fit_intercept);
    if (rejected) res.status = ST_FULL;
    else if (fit_count >= 2) res.status = ST_FIT_VALID;
    else res.status = ST_FEW;
    return res;
  endfunction

  task automatic send_item(input tlr_op_t op, input logic [15:0] sample,
                           input logic [15:0] horizon);
    tlr_in_t item;
    item.opcode = op;
    item.sample = sample;
    item.horizon = horizon;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_trend(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    tlr_out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation: %h", out_data);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.forecast !== exp_res.forecast) begin
          $error("forecast exp %0d got %0d", exp_res.forecast, out_data.forecast);
          error_count++;
        end
        if (out_data.slope_out !== exp_res.slope_out) begin
          $error("slope_out exp %0d got %0d", exp_res.slope_out, out_data.slope_out);
          error_count++;
        end
        if (out_data.intercept_out !== exp_res.intercept_out) begin
          $error("intercept_out exp %0d got %0d", exp_res.intercept_out,
                 out_data.intercept_out);
          error_count++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status exp %0d got %0d", exp_res.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_FORECAST, 16'h0000, 16'h0005);
    send_item(OP_ADD, 16'h7FFF, 16'h0000);
    send_item(OP_FORECAST, 16'h0000, 16'h8000);
    send_item(OP_ADD, 16'h8000, 16'h0000);
    send_item(OP_FORECAST, 16'h0000, 16'h7FFF);
    send_item(OP_FORECAST, 16'h0000, 16'hFFFF);
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
    send_item(OP_ADD, 16'h7FFF, 16'h0000);
    send_item(OP_ADD, 16'h0000, 16'h0000);
    send_item(OP_FORECAST, 16'hFFFF, 16'h8000);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(OP_NONE, 16'h0000, 16'h0000);
    send_item(OP_ADD, 16'h8000, 16'h7FFF);
    send_item(OP_NONE, 16'h0000, 16'h0000);
    send_item(OP_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_item(OP_ADD, 16'(i * 1000 - 2000), 16'h0000);
    send_item(OP_FORECAST, 16'h0000, 16'h0003);
    send_item(OP_CLEAR, 16'h0000, 16'h0000);
  endtask

  // does not fill the count to its limit, with cheap single-sample refits avoided:
  // every add refits, so only a random-length run is practical; the full-count
  // rejection is not reached, as the runs in the random part stay far short of it
  task automatic test_random(input int items);
    int   roll;
    int   span;
    logic [15:0] base;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
      end else if (roll < 6) begin
        send_item(OP_NONE, 16'($urandom), 16'($urandom));
      end else if (roll < 60) begin
        span = $urandom_range(3);
        base = 16'($urandom);
        case (span)
          0: send_item(OP_ADD, base, 16'($urandom));
          1: send_item(OP_ADD, 16'($signed(base) >>> 8), 16'($urandom));
          2: send_item(OP_ADD, ($urandom_range(1)) ? 16'h7FFF : 16'h8000, 16'($urandom));
          default: send_item(OP_ADD, 16'($urandom_range(100)), 16'($urandom));
        endcase
      end else begin
        if ($urandom_range(1)) send_item(OP_FORECAST, 16'($urandom), 16'($urandom));
        else send_item(OP_FORECAST, 16'($urandom),
                       16'($signed(16'($urandom_range(40))) - 16'sd20));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_item(OP_ADD, 16'h1234, 16'h0000);
    send_item(OP_FORECAST, 16'h0000, 16'h0001);
    wait_drained();
    send_item(OP_FORECAST, 16'h0000, 16'hFFFE);
  endtask

  initial begin
    clear_fit();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 78;
    test_directed();
    test_random(250);
    test_pause_until_drained();
    send_idle_pct = 78;
    recv_idle_pct = 25;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(280);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
